@@ hdl/sisk_pkg.sv @@
package sisk_pkg;

   // sequencer states of the sorter
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_EMIT,
      ST_DRAIN
   } sisk_state_type;

endpackage

@@ hdl/stable_insertion_sort_by_key.sv @@
// stable descending insertion sort of {row, col} records
//
// input channel: a word (req_row, req_col, req_last) is taken when start is
// high and busy is low. each word is one record of a set; req_last closes it.
// records are kept in one memory, sorted by row, highest first; equal rows
// keep their arrival order.
// insertion walks the memory from the tail towards the head, one entry a cycle
// through the single read/write port pair: a word is written at once when the
// store is empty and dropped when it is full; otherwise every stored record
// with a smaller row is moved down by one place before the word is placed.
// result channel: after the closing word is inserted, the sorted set follows
// on rsp_* one word a cycle, each marked by rsp_strobe for one cycle; the
// receiver cannot stall and every word must be taken as it appears. the words
// come from the registered memory read port; busy stays high until the final
// word, marked by rsp_out_last, has gone; then the store is empty.
// records beyond MAX_RECORDS are dropped and rsp_overflow is high on the
// whole run of that set.
// reset (synchronous) empties the store and clears the drop flag; memory
// contents need no clearing since only entries below the fill count are read.
module stable_insertion_sort_by_key
   import sisk_pkg::*;
#(
   parameter int MAX_RECORDS = 64,
   parameter int COORD_BITS  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_row,
   input  logic [COORD_BITS-1:0] req_col,
   input  logic                  req_last,
   output logic                  rsp_strobe,
   output logic [COORD_BITS-1:0] rsp_out_row,
   output logic [COORD_BITS-1:0] rsp_out_col,
   output logic                  rsp_out_last,
   output logic                  rsp_overflow
);

   localparam int AW = $clog2(MAX_RECORDS);
   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam int RW = 2 * COORD_BITS;

   sisk_state_type state_ff, state_in;

   // latched record being inserted
   logic [COORD_BITS-1:0] row_ff, col_ff;
   logic                  last_ff;

   // fill count, drop flag, walk / emit index
   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic [AW-1:0] idx_ff, idx_in;

   // read issued for output, word shows next cycle
   logic pend_ff, pend_in;
   logic pend_last_ff, pend_last_in;

   // memory port signals
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [RW-1:0] wr_data, rd_data;

   logic                  accept;
   logic                  full;
   logic [CW-1:0]         count_dec;
   logic [AW-1:0]         tail_addr;
   logic [AW-1:0]         idx_inc;
   logic [COORD_BITS-1:0] rd_row;
   logic                  keep_place;
   logic                  emit_end;

   sisk_ram #(
      .DEPTH (MAX_RECORDS),
      .WIDTH (RW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept     = start && (state_ff == ST_IDLE);
   assign full       = (count_ff == CW'(MAX_RECORDS));
   assign count_dec  = count_ff - CW'(1);
   assign tail_addr  = count_dec[AW-1:0];
   assign idx_inc    = idx_ff + AW'(1);
   assign rd_row     = rd_data[RW-1:COORD_BITS];
   // stored row not below the new one: new record goes right after it
   assign keep_place = (rd_row >= row_ff);
   assign emit_end   = (CW'(idx_ff) == count_dec);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (full || (count_ff == '0)) begin
                  state_in = req_last ? ST_EMIT : ST_IDLE;
               end else begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (keep_place) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end else if (idx_ff == '0) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (emit_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory control and datapath next values
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = {row_ff, col_ff};
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_last_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in = '0;
               if (full) begin
                  drop_in = 1'b1;
               end else if (count_ff == '0) begin
                  // empty store: record lands at the head at once
                  wr_en    = 1'b1;
                  wr_data  = {req_row, req_col};
                  count_in = CW'(1);
               end else begin
                  // start walking from the tail
                  rd_en   = 1'b1;
                  rd_addr = tail_addr;
                  idx_in  = tail_addr;
               end
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_inc;
            if (keep_place) begin
               count_in = count_ff + CW'(1);
               idx_in   = '0;
            end else begin
               // move the smaller record one place down
               wr_data = rd_data;
               if (idx_ff != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - AW'(1);
                  idx_in  = idx_ff - AW'(1);
               end
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            idx_in   = '0;
         end
         ST_EMIT: begin
            rd_en        = 1'b1;
            pend_in      = 1'b1;
            pend_last_in = emit_end;
            if (!emit_end) begin
               idx_in = idx_inc;
            end
         end
         ST_DRAIN: begin
            // final word is on the ports now; empty the store behind it
            count_in = '0;
            drop_in  = 1'b0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         idx_ff       <= idx_in;
      end
   end

   // incoming word held for the walk
   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff  <= req_row;
         col_ff  <= req_col;
         last_ff <= req_last;
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = pend_ff;
   assign rsp_out_row  = rd_data[RW-1:COORD_BITS];
   assign rsp_out_col  = rd_data[COORD_BITS-1:0];
   assign rsp_out_last = pend_last_ff;
   assign rsp_overflow = drop_ff;

endmodule

@@ hdl/sisk_ram.sv @@
module sisk_ram
   import sisk_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
